>>> rtl/ultrasonic_echo_ranger_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the echo ranger checker
// Clocked on clk and muted while rst is high.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

// overlapping implication, checked at every clock edge
`define UER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// non-overlapping implication, consequent checked in the next cycle
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // default sizing
  localparam int SAMPLES_DEF   = 5;
  localparam int ECHO_BITS_DEF = 16;

  // fixed field widths
  localparam int TIMER_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int DIST_W    = 15;

  localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 4'd1;

  localparam logic [CFG_W-1:0] TRIGGER_TICKS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] SETTLE_TICKS_RST  = 16'd1000;

  // one input word
  typedef struct packed {
    logic start_req;
    logic echo;
  } uer_item_t;

  // per-tick status flags travelling down the result pipe
  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
  } uer_flags_t;

endpackage

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic echo ranger: one input word per microsecond tick, one result
// word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one word per 1 us tick with
//   start_req and the sampled echo level. Output channel
//   (out_valid/out_stall): one word per input word with trig, busy_res,
//   done_res and distance_q4 (Q11.4 cm, average of SAMPLES echoes).
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 is the
//   trigger time, index 1 the settle time, both in ticks; write only idle.
// Timing:
//   A word accepted from the input passes the sequencer stage, the
//   reciprocal multiply stage and the output stage to its result word.
//   Throughput is one word per cycle unless out_stall holds a result;
//   the sequencer updates its state in the cycle a word enters the pipe.
// Reset (rst, synchronous): sequencer idle, registers back to 1000 ticks,
//   published distance 0, pipe empty.
// Stall: while out_stall holds a valid result, the pipe freezes; one more
//   input word is absorbed by the input skid stage, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_core
  import uer_pkg::*;
#(
  parameter int SAMPLES   = SAMPLES_DEF,
  parameter int ECHO_BITS = ECHO_BITS_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 start_req,
  input  wire logic                 echo,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      trig,
  output logic                      busy_res,
  output logic                      done_res,
  output logic [DIST_W-1:0]         distance_q4
);

  localparam int SW = ECHO_BITS + $clog2(SAMPLES);

  uer_item_t         in_word;
  uer_item_t         front_word;
  logic              front_valid;
  logic              adv;
  logic              s1_valid;
  uer_flags_t        s1_flags;
  logic [SW-1:0]     s1_sum;
  uer_flags_t        out_flags;

  // whole pipe moves unless a result is held by the receiver
  assign adv = !(out_valid && out_stall);

  assign in_word.start_req = start_req;
  assign in_word.echo      = echo;

  uer_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .adv         (adv),
    .front_valid (front_valid),
    .front_word  (front_word)
  );

  uer_ctrl #(
    .SAMPLES   (SAMPLES),
    .ECHO_BITS (ECHO_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .adv         (adv),
    .front_valid (front_valid),
    .front_word  (front_word),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_sum      (s1_sum)
  );

  uer_div #(
    .SAMPLES   (SAMPLES),
    .ECHO_BITS (ECHO_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_flags  (s1_flags),
    .s1_sum    (s1_sum),
    .out_valid (out_valid),
    .out_flags (out_flags),
    .out_dist  (distance_q4)
  );

  assign trig     = out_flags.trig;
  assign busy_res = out_flags.busy;
  assign done_res = out_flags.done;

endmodule

`default_nettype wire

>>> rtl/uer_skid.sv
// ----------------------------------------------------------------------------
// uer_skid
// Input skid stage: holds one word while the pipe is stalled so that the
// stall seen by the sender is a plain register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_skid
  import uer_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire uer_item_t in_word,
  input  wire logic      adv,
  output logic           front_valid,
  output uer_item_t      front_word
);

  logic      skid_valid;
  uer_item_t skid_word;

  assign in_stall    = skid_valid;
  assign front_valid = skid_valid | in_valid;
  assign front_word  = skid_valid ? skid_word : in_word;

  // capture the incoming word when the pipe does not move
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && !adv) begin
      skid_word <= in_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger, echo wait, echo width count and settle
// pause, one tick per word, plus the configuration registers. Registers the
// per-tick flags and the running width sum into the first result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl
  import uer_pkg::*;
#(
  parameter int SAMPLES   = SAMPLES_DEF,
  parameter int ECHO_BITS = ECHO_BITS_DEF,
  localparam int SW = ECHO_BITS + $clog2(SAMPLES)
)(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 adv,
  input  wire logic                 front_valid,
  input  wire uer_item_t            front_word,
  output logic                      s1_valid,
  output uer_flags_t                s1_flags,
  output logic [SW-1:0]             s1_sum
);

  localparam int IW = $clog2(SAMPLES + 1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIG = 3'd1;
  localparam logic [2:0] PH_WAIT = 3'd2;
  localparam logic [2:0] PH_MEAS = 3'd3;
  localparam logic [2:0] PH_SETL = 3'd4;

  logic [CFG_W-1:0]     trigger_ticks;
  logic [CFG_W-1:0]     settle_ticks;
  logic [2:0]           phase, phase_next;
  logic [TIMER_W-1:0]   phase_timer, phase_timer_next;
  logic [ECHO_BITS-1:0] echo_width, echo_width_next;
  logic [IW-1:0]        sample_index, sample_index_next;
  logic [SW-1:0]        width_sum, width_sum_next;
  uer_flags_t           flags_next;
  logic                 finish;
  logic                 take;

  assign cfg_ready = 1'b1;
  assign take      = front_valid & adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIGGER_TICKS_RST;
      settle_ticks  <= SETTLE_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: trigger_ticks <= cfg_data;
        REG_SETTLE_TICKS:  settle_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one tick of the sequencer
  always_comb begin
    phase_next        = phase;
    phase_timer_next  = phase_timer;
    echo_width_next   = echo_width;
    sample_index_next = sample_index;
    width_sum_next    = width_sum;
    flags_next        = '0;
    finish            = 1'b0;

    if (phase == PH_IDLE && front_word.start_req) begin
      phase_next        = PH_TRIG;
      phase_timer_next  = '0;
      sample_index_next = '0;
      width_sum_next    = '0;
      echo_width_next   = '0;
    end

    case (phase_next)
      PH_TRIG: begin
        flags_next.trig = 1'b1;
        if (phase_timer_next != '1) begin
          phase_timer_next = phase_timer_next + 1'b1;
        end
        if (phase_timer_next >= trigger_ticks) begin
          phase_next       = PH_WAIT;
          phase_timer_next = '0;
        end
      end
      PH_WAIT: begin
        if (front_word.echo) begin
          phase_next      = PH_MEAS;
          echo_width_next = ECHO_BITS'(1);
        end
      end
      PH_MEAS: begin
        if (front_word.echo) begin
          if (echo_width_next != '1) begin
            echo_width_next = echo_width_next + 1'b1;
          end
        end else begin
          width_sum_next  = width_sum_next + SW'(echo_width_next);
          echo_width_next = '0;
          if (settle_ticks == '0) begin
            finish = 1'b1;
          end else begin
            phase_next       = PH_SETL;
            phase_timer_next = '0;
          end
        end
      end
      PH_SETL: begin
        if (phase_timer_next != '1) begin
          phase_timer_next = phase_timer_next + 1'b1;
        end
        if (phase_timer_next >= settle_ticks) begin
          finish = 1'b1;
        end
      end
      PH_IDLE: ;
      default: phase_next = PH_IDLE;
    endcase

    // end of one measurement: next trigger or publish the average
    if (finish) begin
      phase_timer_next = '0;
      if (sample_index_next == IW'(SAMPLES - 1)) begin
        flags_next.done   = 1'b1;
        phase_next        = PH_IDLE;
        sample_index_next = '0;
      end else begin
        phase_next        = PH_TRIG;
        sample_index_next = sample_index_next + 1'b1;
      end
    end

    flags_next.busy = (phase_next != PH_IDLE);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      phase_timer  <= '0;
      echo_width   <= '0;
      sample_index <= '0;
      width_sum    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      phase_timer  <= phase_timer_next;
      echo_width   <= echo_width_next;
      sample_index <= sample_index_next;
      width_sum    <= width_sum_next;
    end
  end

  // first result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= flags_next;
      s1_sum   <= width_sum_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// Average distance: sum*16/(58*SAMPLES) by reciprocal multiply, one
// multiply stage and one output stage holding the last published distance.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_div
  import uer_pkg::*;
#(
  parameter int SAMPLES   = SAMPLES_DEF,
  parameter int ECHO_BITS = ECHO_BITS_DEF,
  localparam int SW = ECHO_BITS + $clog2(SAMPLES)
)(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          s1_valid,
  input  wire uer_flags_t    s1_flags,
  input  wire logic [SW-1:0] s1_sum,
  output logic               out_valid,
  output uer_flags_t         out_flags,
  output logic [DIST_W-1:0]  out_dist
);

  // exact for any dividend below 2**XW with K = XW + clog2(DIV)
  localparam int          DIV   = 58 * SAMPLES;
  localparam int          DW    = $clog2(DIV);
  localparam int          XW    = SW + 4;
  localparam int          K     = XW + DW;
  localparam int          MW    = XW + 1;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam int          PW    = SW + MW;
  localparam int          SH    = K - 4;
  localparam int          QW    = PW - SH;

  logic              s2_valid;
  uer_flags_t        s2_flags;
  logic [PW-1:0]     s2_prod;
  logic [QW-1:0]     quot;
  logic [31:0]       quot_ext;
  logic [DIST_W-1:0] quot_sat;
  logic [DIST_W-1:0] last_distance;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flags <= s1_flags;
      s2_prod  <= PW'(s1_sum) * PW'(RECIP[MW-1:0]);
    end
  end

  // quotient with saturation
  assign quot     = s2_prod[PW-1:SH];
  assign quot_ext = 32'(quot);
  assign quot_sat = (quot_ext > 32'(DIST_MAX)) ? DIST_MAX : quot_ext[DIST_W-1:0];

  // output stage and published distance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_distance <= '0;
    end else if (adv) begin
      out_valid <= s2_valid;
      if (s2_valid && s2_flags.done) begin
        last_distance <= quot_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags <= s2_flags;
      out_dist  <= s2_flags.done ? quot_sat : last_distance;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_checker
  import uer_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 trig,
  input wire logic                 busy_res,
  input wire logic                 done_res,
  input wire logic [DIST_W-1:0]    distance_q4
);

  // a finished run leaves the block idle
  `UER_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res, "done word shows busy")

  // the trigger only fires inside a run
  `UER_ASSERT_IMP(a_trig_busy, out_valid && trig, busy_res, "trigger outside a run")

  // input stalls only after the output was held
  `UER_ASSERT_IMP(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "stall without held output")

  // held result word keeps its distance
  `UER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance_q4), "held output changed")

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for ultrasonic_echo_ranger_core
// Drives one tick word per input handshake. A cycle-level model of the
// ranger predicts trig, busy, done and the published distance for every
// accepted word. The checker compares each result word against the oldest
// prediction. Directed runs cover the register extremes, zero trigger and
// settle times, starts while busy and unknown register writes. Random runs
// follow with well-formed echo pulses and some noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import uer_pkg::*;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1050;
  localparam int ECHO_MAX     = (1 << ECHO_BITS_DEF) - 1;
  localparam int CM_DIV       = 58 * SAMPLES_DEF;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS, PH_SETL
  } ranger_phase_e;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] distance;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic start_req;
  logic echo;
  logic out_valid;
  logic out_stall;
  logic trig;
  logic busy_res;
  logic done_res;
  logic [DIST_W-1:0] distance_q4;

  // ranger model state
  logic [CFG_W-1:0]         trig_ticks_m;
  logic [CFG_W-1:0]         settle_ticks_m;
  ranger_phase_e            phase_m;
  logic [TIMER_W-1:0]       timer_m;
  logic [ECHO_BITS_DEF-1:0] width_m;
  logic [2:0]               idx_m;
  logic [18:0]              sum_m;
  logic [DIST_W-1:0]        dist_m;

  tick_result_t expected_q[$];

  // echo pulse shaping
  int  wait_left = 0;
  int  high_left = 0;
  int  wait_hi = 3;
  int  width_lo = 1;
  int  width_hi = 20;
  int  noise_pct = 0;
  int  start_idle_pct = 50;
  int  start_busy_pct = 10;

  bit  idle_on = 1;
  bit  hold_req = 0;
  int  fail_count = 0;
  int  cycle_count = 0;

  ultrasonic_echo_ranger_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_req   (start_req),
    .echo        (echo),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .trig        (trig),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .distance_q4 (distance_q4)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end of one measurement; publishes the average after the last one
  function automatic logic close_sample();
    logic [31:0] q;
    idx_m = idx_m + 3'd1;
    if (idx_m >= SAMPLES_DEF) begin
      q = 32'(sum_m);
      q = (q << 4) / CM_DIV;
      dist_m = (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
      phase_m = PH_IDLE;
      idx_m = '0;
      timer_m = '0;
      return 1'b1;
    end
    phase_m = PH_TRIG;
    timer_m = '0;
    return 1'b0;
  endfunction

  // one tick of the ranger sequencer
  function automatic tick_result_t ranger_step(input logic st, input logic ec);
    tick_result_t r;
    r = '0;
    if (phase_m == PH_IDLE && st) begin
      phase_m = PH_TRIG;
      timer_m = '0;
      idx_m = '0;
      sum_m = '0;
      width_m = '0;
    end
    case (phase_m)
      PH_TRIG: begin
        r.trig = 1'b1;
        if (timer_m != 16'hFFFF) timer_m = timer_m + 16'd1;
        if (timer_m >= trig_ticks_m) begin
          phase_m = PH_WAIT;
          timer_m = '0;
        end
      end
      PH_WAIT: begin
        if (ec) begin
          phase_m = PH_MEAS;
          width_m = 16'd1;
        end
      end
      PH_MEAS: begin
        if (ec) begin
          if (width_m < ECHO_MAX) width_m = width_m + 16'd1;
        end else begin
          sum_m = sum_m + 19'(width_m);
          width_m = '0;
          if (settle_ticks_m == 0) begin
            r.done = close_sample();
          end else begin
            phase_m = PH_SETL;
            timer_m = '0;
          end
        end
      end
      PH_SETL: begin
        if (timer_m != 16'hFFFF) timer_m = timer_m + 16'd1;
        if (timer_m >= settle_ticks_m) r.done = close_sample();
      end
      default: phase_m = PH_IDLE;
    endcase
    r.busy = (phase_m != PH_IDLE);
    r.distance = dist_m;
    return r;
  endfunction

  // echo level that follows a pulse plan, with optional noise
  function automatic logic next_echo();
    logic e;
    case (phase_m)
      PH_WAIT: begin
        if (wait_left > 0) begin
          wait_left = wait_left - 1;
          e = 1'b0;
        end else begin
          e = 1'b1;
          high_left = $urandom_range(width_lo, width_hi) - 1;
        end
      end
      PH_MEAS: begin
        if (high_left > 0) begin
          high_left = high_left - 1;
          e = 1'b1;
        end else begin
          e = 1'b0;
          wait_left = $urandom_range(0, wait_hi);
        end
      end
      default: e = 1'($urandom_range(0, 1));
    endcase
    if ($urandom_range(1, 100) <= noise_pct) e = 1'($urandom_range(0, 1));
    return e;
  endfunction

  function automatic logic pick_start();
    if (phase_m == PH_IDLE) return ($urandom_range(1, 100) <= start_idle_pct);
    return ($urandom_range(1, 100) <= start_busy_pct);
  endfunction

  // send one tick word, then predict its result
  task automatic send_tick(input logic st, input logic ec);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    start_req = st;
    echo = ec;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(ranger_step(st, ec));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TRIGGER_TICKS) trig_ticks_m = data;
    else if (idx == REG_SETTLE_TICKS) settle_ticks_m = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(pick_start(), next_echo());
  endtask

  // start a run (if idle) and tick until the sequencer is idle again
  task automatic run_measurement();
    send_tick(1'b1, next_echo());
    while (phase_m != PH_IDLE) send_tick(pick_start(), next_echo());
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_result
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("trig", want.trig, trig);
        check_field("busy_res", want.busy, busy_res);
        check_field("done_res", want.done, done_res);
        check_field("distance_q4", want.distance, distance_q4);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ultrasonic_echo_ranger_core: mismatch");
      $finish;
    end
  end

  // idle ticks after reset, then a run on the reset register values;
  // the long trigger is cut short by a write once it has been seen held
  task automatic test_reset_defaults();
    start_idle_pct = 0;
    repeat (8) send_tick(1'b0, next_echo());
    start_idle_pct = 50;
    width_lo = 1;
    width_hi = 40;
    wait_hi = 5;
    send_tick(1'b1, next_echo());
    run_ticks(50);
    wait_results_drained();
    write_reg(REG_TRIGGER_TICKS, 16'd12);
    write_reg(REG_SETTLE_TICKS, 16'd3);
    while (phase_m != PH_IDLE) send_tick(pick_start(), next_echo());
    wait_results_drained();
  endtask

  // zero trigger and zero settle: shortest runs with one-tick echoes, then wider ones
  task automatic test_zero_timing();
    write_reg(REG_TRIGGER_TICKS, 16'd0);
    write_reg(REG_SETTLE_TICKS, 16'd0);
    width_lo = 1;
    width_hi = 1;
    wait_hi = 0;
    run_measurement();
    width_hi = 3;
    run_measurement();
    wait_results_drained();
  endtask

  // start held high through a whole run, then an immediate restart
  task automatic test_start_while_busy();
    write_reg(REG_TRIGGER_TICKS, 16'd10);
    write_reg(REG_SETTLE_TICKS, 16'd5);
    width_hi = 12;
    wait_hi = 3;
    start_busy_pct = 100;
    run_measurement();
    run_measurement();
    start_busy_pct = 10;
    wait_results_drained();
  endtask

  // maximum register values, cut short by writes in the middle of a run
  task automatic test_register_extremes();
    write_reg(REG_TRIGGER_TICKS, 16'hFFFF);
    write_reg(REG_SETTLE_TICKS, 16'hFFFF);
    send_tick(1'b1, next_echo());
    run_ticks(40);
    wait_results_drained();
    // timer is already past the new value: trigger ends on the next tick
    write_reg(REG_TRIGGER_TICKS, 16'd12);
    while (phase_m != PH_SETL) send_tick(pick_start(), next_echo());
    run_ticks(30);
    wait_results_drained();
    write_reg(REG_SETTLE_TICKS, 16'd4);
    run_measurement();
    wait_results_drained();
  endtask

  // writes to unmapped indexes must leave both registers alone
  task automatic test_unknown_index();
    for (int i = 2; i < 16; i++) write_reg(CFG_IDX_W'(i), CFG_W'($urandom_range(0, 65535)));
    write_reg(4'hF, 16'hFFFF);
    run_measurement();
    wait_results_drained();
  endtask

  // long receiver hold while words keep coming, then a full drain
  task automatic test_backpressure();
    write_reg(REG_TRIGGER_TICKS, 16'd3);
    write_reg(REG_SETTLE_TICKS, 16'd2);
    width_hi = 10;
    hold_req = 1;
    run_ticks(60);
    wait_results_drained();
  endtask

  // random segments, each with its own register setting
  task automatic test_random();
    int total;
    int n;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      n = $urandom_range(100, 250);
      idle_on = (total < RANDOM_ITEMS - 400) && ($urandom_range(0, 3) != 0);
      wait_results_drained();
      write_reg(REG_TRIGGER_TICKS, CFG_W'($urandom_range(0, 12)));
      write_reg(REG_SETTLE_TICKS,
                CFG_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8)));
      noise_pct = ($urandom_range(0, 3) == 0) ? 15 : 0;
      width_lo = 1;
      width_hi = $urandom_range(1, 30);
      wait_hi = $urandom_range(0, 6);
      start_idle_pct = 40;
      start_busy_pct = 10;
      run_ticks(n);
      total += n;
    end
    wait_results_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    start_req = 1'b0;
    echo = 1'b0;
    trig_ticks_m = TRIGGER_TICKS_RST;
    settle_ticks_m = SETTLE_TICKS_RST;
    phase_m = PH_IDLE;
    timer_m = '0;
    width_m = '0;
    idx_m = '0;
    sum_m = '0;
    dist_m = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_zero_timing();
    test_start_while_busy();
    test_register_extremes();
    test_unknown_index();
    test_backpressure();
    test_random();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ultrasonic_echo_ranger_core: match");
    end else begin
      $display("ultrasonic_echo_ranger_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_skid.sv
rtl/uer_ctrl.sv
rtl/uer_div.sv
rtl/ultrasonic_echo_ranger_core.sv
rtl/uer_checker.sv
tb/tb.sv
